/* rtl/core/ffta_pkg.sv */
// Shared types and constants for the first-fit tile allocator.
// No dependencies; used by every module of the allocator.
`default_nettype none

package ffta_pkg;

  // Field widths of requests, results and grid registers
  localparam int FIELD_W = 6;
  localparam int POS_W = 5;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W = 8;

  // Default grid bounds
  localparam int DEF_MAX_COLUMNS = 32;
  localparam int DEF_MAX_ROWS = 32;

  // Grid register reset value
  localparam logic [FIELD_W-1:0] GRID_RESET = 6'd32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 8'd1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_RESULT
  } state_t;

  // Occupancy memory access request
  typedef struct packed {
    logic               rd_en;
    logic [FIELD_W-1:0] rd_row;
    logic               wr_en;
    logic [FIELD_W-1:0] wr_row;
  } mem_req_t;

  // Fit unit control
  typedef struct packed {
    logic               clear;
    logic               update;
    logic [FIELD_W-1:0] need_w;
    logic [FIELD_W-1:0] need_h;
    logic [FIELD_W-1:0] cols;
  } fit_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/ffta_occ_mem.sv */
// Occupancy bitmap memory: one word per grid row, registered read.
// Per-row valid bits make never-written rows read as free. Uses ffta_pkg.
`default_nettype none

module ffta_occ_mem #(
  parameter int MAX_COLUMNS = ffta_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS = ffta_pkg::DEF_MAX_ROWS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ffta_pkg::mem_req_t     req,
  input  wire logic [MAX_COLUMNS-1:0] wr_data,
  output logic      [MAX_COLUMNS-1:0] rd_data
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [MAX_COLUMNS-1:0] mem [0:MAX_ROWS-1];
  logic [MAX_ROWS-1:0]    row_valid;

  // Row valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (req.wr_en) begin
      row_valid[req.wr_row[AW-1:0]] <= 1'b1;
    end
  end

  // Storage write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_row[AW-1:0]] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data <= row_valid[req.rd_row[AW-1:0]] ? mem[req.rd_row[AW-1:0]] : '0;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ffta_fit_unit.sv */
// Fit unit: per-column free-run counters and a run finder over one row.
// Reports the leftmost column with a free rectangle ending at the last row fed.
// Uses ffta_pkg.
`default_nettype none

module ffta_fit_unit #(
  parameter int MAX_COLUMNS = ffta_pkg::DEF_MAX_COLUMNS
) (
  input  wire logic                           clk,
  input  wire ffta_pkg::fit_ctl_t             ctl,
  input  wire logic [MAX_COLUMNS-1:0]         row_word,
  output logic                                hit,
  output logic      [ffta_pkg::FIELD_W-1:0]   hit_col
);

  localparam int FW = ffta_pkg::FIELD_W;

  logic [FW-1:0]          vrun [0:MAX_COLUMNS-1];
  logic [MAX_COLUMNS-1:0] free_cols;
  logic [MAX_COLUMNS-1:0] runs [0:FW-1];
  logic [MAX_COLUMNS-1:0] fit_cols;

  // Count of consecutive free rows per column, saturating
  always_ff @(posedge clk) begin
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      if (ctl.clear) begin
        vrun[c] <= '0;
      end else if (ctl.update) begin
        if (row_word[c]) begin
          vrun[c] <= '0;
        end else if (vrun[c] != {FW{1'b1}}) begin
          vrun[c] <= vrun[c] + 1'b1;
        end
      end
    end
  end

  // Columns free over the last need_h rows and inside the grid
  always_comb begin
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      free_cols[c] = (vrun[c] >= ctl.need_h) && (7'(c) < {1'b0, ctl.cols});
    end
  end

  // Horizontal runs of need_w free columns by power-of-two doubling
  always_comb begin
    logic [FW:0] off;
    off = '0;
    runs[0] = free_cols;
    for (int j = 1; j < FW; j++) begin
      runs[j] = runs[j-1] & (runs[j-1] >> (1 << (j - 1)));
    end
    fit_cols = '1;
    for (int j = 0; j < FW; j++) begin
      if (ctl.need_w[j]) begin
        fit_cols = fit_cols & (runs[j] >> off);
        off = off + 7'(1 << j);
      end
    end
  end

  // Leftmost fitting column
  always_comb begin
    hit_col = '0;
    for (int c = MAX_COLUMNS - 1; c >= 0; c--) begin
      if (fit_cols[c]) begin
        hit_col = FW'(c);
      end
    end
    hit = |fit_cols;
  end

endmodule

`default_nettype wire

/* rtl/core/first_fit_tile_allocator.sv */
// A zero-size tile or a grid with no rows is answered without a scan. Otherwise the scan
// reads one memory row per cycle from row 0 until a fit is found or the last row is checked;
// a placed tile then has its rows marked in the occupancy memory before the result is loaded.
// One request at a time: s_tready is high only while idle, after the last result is loaded;
// a pending result may wait on m_tready. Reset frees all cells and sets both grid sizes to 32.
// Depends on ffta_pkg, ffta_occ_mem and ffta_fit_unit.
`default_nettype none

module first_fit_tile_allocator #(
  parameter int MAX_COLUMNS = ffta_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS = ffta_pkg::DEF_MAX_ROWS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // tile_width [5:0], tile_height [11:6], zero pad
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [ffta_pkg::IN_TDATA_W-1:0]   s_tdata,
  // placed [0], anchor_column [5:1], anchor_row [10:6], zero pad
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [ffta_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // grid register writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ffta_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ffta_pkg::FIELD_W-1:0]      cfg_data
);

  localparam int FW = ffta_pkg::FIELD_W;
  localparam int PW = ffta_pkg::POS_W;

  ffta_pkg::state_t state, state_next;

  logic [FW-1:0] grid_columns, grid_rows;
  logic [FW-1:0] cols_now, rows_now;
  logic [FW-1:0] req_w, req_h;
  logic          s_accept, imm, imm_placed;

  logic [FW-1:0] tw, th, cols_eff, rows_eff;
  logic [FW-1:0] rd_row, row_d1, ev_row;
  logic          scan_d1, ev_valid, scan_rd;
  logic [FW-1:0] mk_row, mk_left, mk_wrow;
  logic          mk_pend;
  logic [MAX_COLUMNS-1:0] mask;
  logic          res_placed;
  logic [FW-1:0] res_col, res_row;
  logic          out_load, hit, scan_hit, scan_miss;
  logic [FW-1:0] hit_col, hit_row;

  ffta_pkg::mem_req_t     mem_req;
  ffta_pkg::fit_ctl_t     fit_ctl;
  logic [MAX_COLUMNS-1:0] rd_data, wr_data;

  assign cfg_ready = 1'b1;
  assign req_w = s_tdata[FW-1:0];
  assign req_h = s_tdata[2*FW-1:FW];
  assign s_accept = s_tvalid && s_tready;

  // Grid sizes clamped to the storage bounds
  assign cols_now = (7'(grid_columns) > 7'(MAX_COLUMNS)) ? FW'(MAX_COLUMNS) : grid_columns;
  assign rows_now = (7'(grid_rows) > 7'(MAX_ROWS)) ? FW'(MAX_ROWS) : grid_rows;

  // Requests answered without a scan: empty tile or a grid with no rows
  assign imm = (req_w == '0) || (req_h == '0) || (rows_now == '0);
  assign imm_placed = ((req_w == '0) || (req_h == '0)) && (rows_now != '0) &&
                      (cols_now != '0) && (req_w <= cols_now) && (req_h <= rows_now);

  assign scan_hit = (state == ffta_pkg::ST_SCAN) && ev_valid && hit;
  assign scan_miss = (state == ffta_pkg::ST_SCAN) && ev_valid && !hit &&
                     (ev_row == rows_eff - 1'b1);
  assign hit_row = ev_row + 1'b1 - th;
  assign out_load = (state == ffta_pkg::ST_RESULT) && (!m_tvalid || m_tready);
  assign scan_rd = (state == ffta_pkg::ST_SCAN) && (rd_row < rows_eff);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ffta_pkg::ST_IDLE: begin
        if (s_accept) begin
          state_next = imm ? ffta_pkg::ST_RESULT : ffta_pkg::ST_SCAN;
        end
      end
      ffta_pkg::ST_SCAN: begin
        if (scan_hit) begin
          state_next = ffta_pkg::ST_MARK;
        end else if (scan_miss) begin
          state_next = ffta_pkg::ST_RESULT;
        end
      end
      ffta_pkg::ST_MARK: begin
        if (mk_left == '0 && !mk_pend) begin
          state_next = ffta_pkg::ST_RESULT;
        end
      end
      ffta_pkg::ST_RESULT: begin
        if (out_load) begin
          state_next = ffta_pkg::ST_IDLE;
        end
      end
      default: state_next = ffta_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, memory port, fit unit control
  always_comb begin
    s_tready = (state == ffta_pkg::ST_IDLE);
    mem_req.rd_en = 1'b0;
    mem_req.rd_row = rd_row;
    mem_req.wr_en = 1'b0;
    mem_req.wr_row = mk_wrow;
    unique case (state)
      ffta_pkg::ST_SCAN: begin
        mem_req.rd_en = scan_rd;
      end
      ffta_pkg::ST_MARK: begin
        mem_req.rd_en = (mk_left != '0);
        mem_req.rd_row = mk_row;
        mem_req.wr_en = mk_pend;
      end
      default: begin
      end
    endcase
    wr_data = rd_data | mask;
    fit_ctl.clear = s_accept;
    fit_ctl.update = (state == ffta_pkg::ST_SCAN) && scan_d1;
    fit_ctl.need_w = tw;
    fit_ctl.need_h = th;
    fit_ctl.cols = cols_eff;
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffta_pkg::ST_IDLE;
      grid_columns <= ffta_pkg::GRID_RESET;
      grid_rows <= ffta_pkg::GRID_RESET;
      scan_d1 <= 1'b0;
      ev_valid <= 1'b0;
      mk_pend <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ffta_pkg::REG_GRID_COLUMNS) begin
          grid_columns <= cfg_data;
        end else if (cfg_index == ffta_pkg::REG_GRID_ROWS) begin
          grid_rows <= cfg_data;
        end
      end
      if (s_accept) begin
        scan_d1 <= 1'b0;
        ev_valid <= 1'b0;
      end else begin
        scan_d1 <= scan_rd;
        ev_valid <= scan_d1 && (state == ffta_pkg::ST_SCAN);
      end
      mk_pend <= (state == ffta_pkg::ST_MARK) && (mk_left != '0);
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (s_accept) begin
      tw <= req_w;
      th <= req_h;
      cols_eff <= cols_now;
      rows_eff <= rows_now;
      rd_row <= '0;
      res_placed <= imm_placed;
      res_col <= '0;
      res_row <= '0;
      mk_left <= '0;
    end
    if (scan_rd) begin
      rd_row <= rd_row + 1'b1;
    end
    row_d1 <= rd_row;
    ev_row <= row_d1;
    // Found: remember anchor and the row mask to mark
    if (scan_hit) begin
      res_placed <= 1'b1;
      res_col <= hit_col;
      res_row <= hit_row;
      mask <= (~({MAX_COLUMNS{1'b1}} << tw)) << hit_col;
      mk_row <= hit_row;
      mk_left <= th;
    end else if (scan_miss) begin
      res_placed <= 1'b0;
      res_col <= '0;
      res_row <= '0;
    end
    // Mark: read row, write it back with the mask in the next cycle
    if ((state == ffta_pkg::ST_MARK) && (mk_left != '0)) begin
      mk_row <= mk_row + 1'b1;
      mk_left <= mk_left - 1'b1;
    end
    mk_wrow <= mk_row;
    if (out_load) begin
      m_tdata <= {(ffta_pkg::OUT_TDATA_W - 1 - 2 * PW)'(0), res_row[PW-1:0],
                  res_col[PW-1:0], res_placed};
    end
  end

  ffta_occ_mem #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS(MAX_ROWS)
  ) u_occ_mem (
    .clk(clk),
    .rst(rst),
    .req(mem_req),
    .wr_data(wr_data),
    .rd_data(rd_data)
  );

  ffta_fit_unit #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_fit_unit (
    .clk(clk),
    .ctl(fit_ctl),
    .row_word(rd_data),
    .hit(hit),
    .hit_col(hit_col)
  );

endmodule

`default_nettype wire

/* rtl/core/ffta_checker.sv */
// Port-level checks for the first-fit tile allocator, bound to the top level.
// Depends on ffta_pkg and first_fit_tile_allocator.
`default_nettype none

module ffta_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tvalid,
  input wire logic                              s_tready,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [ffta_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // A result that is not placed carries a zero anchor
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[10:1] == 10'd0)
    else $error("non-placed result with nonzero anchor");

  // One request at a time: busy right after accepting
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while busy");

endmodule

bind first_fit_tile_allocator ffta_checker u_ffta_checker (
  .clk(clk),
  .rst(rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);

`default_nettype wire

/* tb/first_fit_tile_allocator_tb.sv */
// Self-checking testbench for first_fit_tile_allocator: directed table, then random tiles
// over several grid settings, each result checked against a bitmap predictor or a table entry.
// Depends on ffta_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module first_fit_tile_allocator_tb;

  localparam int GRID_MAX_COLS = ffta_pkg::DEF_MAX_COLUMNS;
  localparam int GRID_MAX_ROWS = ffta_pkg::DEF_MAX_ROWS;
  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 80;
  localparam int ITEMS_PER_PHASE = 228;
  localparam int NUM_PHASES = 8;

  // indexes outside the register file; writes to them must be dropped
  localparam logic [ffta_pkg::CFG_IDX_W-1:0] REG_NONE_LOW = 8'd2;
  localparam logic [ffta_pkg::CFG_IDX_W-1:0] REG_NONE_HIGH = 8'hFF;

  typedef enum logic [1:0] {
    PACE_NONE,
    PACE_SENDER,
    PACE_RECEIVER,
    PACE_BOTH
  } pace_t;

  typedef enum logic {
    DO_REQUEST,
    DO_WRITE
  } step_kind_t;

  typedef struct packed {
    logic       placed;
    logic [4:0] col;
    logic [4:0] row;
  } anchor_t;

  typedef struct packed {
    step_kind_t                     kind;
    logic [ffta_pkg::CFG_IDX_W-1:0] index;
    logic [ffta_pkg::FIELD_W-1:0]   value;
    logic [ffta_pkg::FIELD_W-1:0]   w;
    logic [ffta_pkg::FIELD_W-1:0]   h;
    logic                           typed;
    anchor_t                        exp;
  } step_t;

  localparam anchor_t MISS = '{1'b0, 5'd0, 5'd0};
  localparam anchor_t ORIGIN = '{1'b1, 5'd0, 5'd0};

  // directed table; rows with typed = 0 are checked against the predictor
  localparam int DIRECTED_LEN = 31;
  localparam step_t DIRECTED_STEPS [DIRECTED_LEN] = '{
    '{DO_REQUEST, '0, 6'd0, 6'd1, 6'd1, 1'b1, ORIGIN},
    '{DO_REQUEST, '0, 6'd0, 6'd0, 6'd5, 1'b1, ORIGIN},
    '{DO_REQUEST, '0, 6'd0, 6'd4, 6'd0, 1'b1, ORIGIN},
    '{DO_REQUEST, '0, 6'd0, 6'd33, 6'd1, 1'b1, MISS},
    '{DO_REQUEST, '0, 6'd0, 6'd1, 6'd63, 1'b1, MISS},
    '{DO_REQUEST, '0, 6'd0, 6'd63, 6'd63, 1'b1, MISS},
    '{DO_REQUEST, '0, 6'd0, 6'd32, 6'd1, 1'b0, MISS},
    '{DO_REQUEST, '0, 6'd0, 6'd31, 6'd1, 1'b0, MISS},
    '{DO_REQUEST, '0, 6'd0, 6'd2, 6'd2, 1'b0, MISS},
    '{DO_WRITE, REG_NONE_LOW, 6'd1, 6'd0, 6'd0, 1'b0, MISS},
    '{DO_WRITE, REG_NONE_HIGH, 6'd0, 6'd0, 6'd0, 1'b0, MISS},
    '{DO_REQUEST, '0, 6'd0, 6'd1, 6'd1, 1'b0, MISS},
    '{DO_WRITE, ffta_pkg::REG_GRID_COLUMNS, 6'd0, 6'd0, 6'd0, 1'b0, MISS},
    '{DO_REQUEST, '0, 6'd0, 6'd1, 6'd1, 1'b1, MISS},
    '{DO_REQUEST, '0, 6'd0, 6'd0, 6'd0, 1'b1, MISS},
    '{DO_WRITE, ffta_pkg::REG_GRID_COLUMNS, 6'd63, 6'd0, 6'd0, 1'b0, MISS},
    '{DO_WRITE, ffta_pkg::REG_GRID_ROWS, 6'd0, 6'd0, 6'd0, 1'b0, MISS},
    '{DO_REQUEST, '0, 6'd0, 6'd0, 6'd0, 1'b1, MISS},
    '{DO_WRITE, ffta_pkg::REG_GRID_ROWS, 6'd63, 6'd0, 6'd0, 1'b0, MISS},
    '{DO_REQUEST, '0, 6'd0, 6'd32, 6'd32, 1'b0, MISS},
    '{DO_REQUEST, '0, 6'd0, 6'd0, 6'd1, 1'b0, MISS},
    '{DO_WRITE, ffta_pkg::REG_GRID_COLUMNS, 6'd1, 6'd0, 6'd0, 1'b0, MISS},
    '{DO_WRITE, ffta_pkg::REG_GRID_ROWS, 6'd1, 6'd0, 6'd0, 1'b0, MISS},
    '{DO_REQUEST, '0, 6'd0, 6'd1, 6'd1, 1'b0, MISS},
    '{DO_REQUEST, '0, 6'd0, 6'd1, 6'd0, 1'b0, MISS},
    '{DO_WRITE, ffta_pkg::REG_GRID_COLUMNS, 6'd32, 6'd0, 6'd0, 1'b0, MISS},
    '{DO_WRITE, ffta_pkg::REG_GRID_ROWS, 6'd32, 6'd0, 6'd0, 1'b0, MISS},
    '{DO_REQUEST, '0, 6'd0, 6'd1, 6'd30, 1'b0, MISS},
    '{DO_REQUEST, '0, 6'd0, 6'd32, 6'd2, 1'b0, MISS},
    '{DO_REQUEST, '0, 6'd0, 6'd5, 6'd3, 1'b0, MISS},
    '{DO_REQUEST, '0, 6'd0, 6'd2, 6'd33, 1'b1, MISS}
  };

  // grid settings of the random phases; small grids first so the map fills gradually
  localparam logic [ffta_pkg::FIELD_W-1:0] PHASE_COLS [NUM_PHASES] = '{
    6'd4, 6'd9, 6'd12, 6'd20, 6'd32, 6'd63, 6'd1, 6'd32
  };
  localparam logic [ffta_pkg::FIELD_W-1:0] PHASE_ROWS [NUM_PHASES] = '{
    6'd4, 6'd3, 6'd14, 6'd7, 6'd20, 6'd32, 6'd63, 6'd32
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [ffta_pkg::IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [ffta_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ffta_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ffta_pkg::FIELD_W-1:0] cfg_data = '0;

  // predictor state: occupancy map and grid registers
  logic [GRID_MAX_COLS-1:0] taken_rows [GRID_MAX_ROWS];
  int grid_cols = int'(ffta_pkg::GRID_RESET);
  int grid_rows = int'(ffta_pkg::GRID_RESET);

  anchor_t pending_anchors [$];
  int mismatch_count = 0;
  int quiet_cycles = 0;
  pace_t pace_mode = PACE_NONE;

  first_fit_tile_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // first-fit scan over the occupancy map; claims the cells of a winning anchor
  function automatic anchor_t fit_and_claim_tile(logic [ffta_pkg::FIELD_W-1:0] w,
                                                 logic [ffta_pkg::FIELD_W-1:0] h);
    int cols;
    int rows;
    int r;
    int c;
    int k;
    logic [63:0] span;
    bit clash;
    bit found;
    anchor_t res;
    cols = (grid_cols > GRID_MAX_COLS) ? GRID_MAX_COLS : grid_cols;
    rows = (grid_rows > GRID_MAX_ROWS) ? GRID_MAX_ROWS : grid_rows;
    res = MISS;
    found = 1'b0;
    for (r = 0; r < rows && r + int'(h) <= rows && !found; r++) begin
      for (c = 0; c < cols && c + int'(w) <= cols && !found; c++) begin
        span = (w == 0) ? 64'd0 : (((64'd1 << w) - 64'd1) << c);
        clash = 1'b0;
        for (k = 0; k < int'(h); k++) begin
          if ((taken_rows[r + k] & span[GRID_MAX_COLS-1:0]) != '0) clash = 1'b1;
        end
        if (!clash) begin
          found = 1'b1;
          for (k = 0; k < int'(h); k++) taken_rows[r + k] |= span[GRID_MAX_COLS-1:0];
          res = '{1'b1, c[4:0], r[4:0]};
        end
      end
    end
    return res;
  endfunction

  // one random idle decision for the sender or the receiver under the current pacing
  function automatic bit pace_holds(bit receiver_side);
    int pct;
    case (pace_mode)
      PACE_SENDER:   pct = receiver_side ? 0 : 76;
      PACE_RECEIVER: pct = receiver_side ? 76 : 0;
      PACE_BOTH:     pct = 8;
      default:       pct = 0;
    endcase
    return $urandom_range(99) < pct;
  endfunction

  // tile side: mostly small, some empty, a few beyond the grid
  function automatic logic [ffta_pkg::FIELD_W-1:0] pick_side();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    else if (roll < 70) return (ffta_pkg::FIELD_W)'($urandom_range(3, 1));
    else if (roll < 90) return (ffta_pkg::FIELD_W)'($urandom_range(10, 4));
    else if (roll < 97) return (ffta_pkg::FIELD_W)'($urandom_range(32, 11));
    else return (ffta_pkg::FIELD_W)'($urandom_range(63, 33));
  endfunction

  // send one tile request; the expectation is formed at acceptance
  task automatic issue_request(logic [ffta_pkg::FIELD_W-1:0] w,
                               logic [ffta_pkg::FIELD_W-1:0] h, bit typed,
                               anchor_t typed_exp);
    anchor_t predicted;
    while (pace_holds(1'b0)) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(ffta_pkg::IN_TDATA_W - 2 * ffta_pkg::FIELD_W){1'b0}}, h, w};
    do @(posedge clk); while (!s_tready);
    predicted = fit_and_claim_tile(w, h);
    pending_anchors.push_back(typed ? typed_exp : predicted);
  endtask

  // wait until every result is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_anchors.size() != 0) @(posedge clk);
  endtask

  // grid register write, only with the block idle
  task automatic write_grid_reg(logic [ffta_pkg::CFG_IDX_W-1:0] idx,
                                logic [ffta_pkg::FIELD_W-1:0] value);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == ffta_pkg::REG_GRID_COLUMNS) grid_cols = int'(value);
    else if (idx == ffta_pkg::REG_GRID_ROWS) grid_rows = int'(value);
    cfg_valid <= 1'b0;
  endtask

  // result checking and receiver stalls
  always @(posedge clk) begin
    anchor_t want;
    anchor_t got;
    if (m_tvalid && m_tready) begin
      got = '{m_tdata[0], m_tdata[5:1], m_tdata[10:6]};
      if (pending_anchors.size() == 0) begin
        $error("result with no request pending: placed %0d col %0d row %0d",
               got.placed, got.col, got.row);
        mismatch_count++;
      end else begin
        want = pending_anchors.pop_front();
        if (got.placed !== want.placed) begin
          $error("placed: expected %0d, got %0d", want.placed, got.placed);
          mismatch_count++;
        end
        if (got.col !== want.col) begin
          $error("anchor_column: expected %0d, got %0d", want.col, got.col);
          mismatch_count++;
        end
        if (got.row !== want.row) begin
          $error("anchor_row: expected %0d, got %0d", want.row, got.row);
          mismatch_count++;
        end
      end
    end
    m_tready <= rst ? 1'b0 : !pace_holds(1'b1);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    step_t st;
    for (int r = 0; r < GRID_MAX_ROWS; r++) taken_rows[r] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < DIRECTED_LEN; i++) begin
      st = DIRECTED_STEPS[i];
      if (st.kind == DO_WRITE) write_grid_reg(st.index, st.value);
      else issue_request(st.w, st.h, st.typed, st.exp);
    end

    // random phases, each with its own grid and pacing
    for (int p = 0; p < NUM_PHASES; p++) begin
      pace_mode = pace_t'(p % 4);
      write_grid_reg(ffta_pkg::REG_GRID_COLUMNS, PHASE_COLS[p]);
      write_grid_reg(ffta_pkg::REG_GRID_ROWS, PHASE_ROWS[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) issue_request(pick_side(), pick_side(), 1'b0, MISS);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
